@@ sv/gdfs_pkg.sv @@
// types, constants and codes shared by the graph search block
// no dependencies
package gdfs_pkg;

    localparam int NUM_VERTICES_DEF = 16;
    localparam int VERT_W           = 8;
    localparam int VIS_W            = 4;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_INS_VERTEX = 2'd1,
        OP_INS_EDGE   = 2'd2,
        OP_SEARCH     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_EXISTS      = 3'd1,
        STAT_INVALID     = 3'd2,
        STAT_MISSING     = 3'd3,
        STAT_EDGE_EXISTS = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [VERT_W-1:0]  vertex;
        logic [VERT_W-1:0]  other_vertex;
    } cmd_t;

    typedef struct packed {
        logic [VIS_W-1:0]   visited_vertex;
        status_t            status;
        logic               last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_A,
        S_EDGE_B,
        S_REPORT,
        S_ROW_RD,
        S_PICK,
        S_POP_RD,
        S_POP_TOP,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        ASEL_A,
        ASEL_B,
        ASEL_PEND,
        ASEL_STACK
    } adj_sel_t;

    typedef struct packed {
        logic       latch_cmd;
        logic       clear_graph;
        logic       set_present;
        logic       adj_rd;
        adj_sel_t   adj_sel;
        logic       adj_wr;
        logic       adj_wr_b;
        logic       search_init;
        logic       push;
        logic       pop;
        logic       stack_rd;
        logic       emit_status;
        status_t    rsp_status;
        logic       emit_pend;
        logic       emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t    op;
        logic   v_bad;
        logic   u_bad;
        logic   v_present;
        logic   u_present;
        logic   same;
        logic   edge_set;
        logic   open_any;
        logic   depth_one;
        logic   slot_free;
    } dp_stat_t;

endpackage

@@ sv/gdfs_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module gdfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gdfs_ctrl.sv @@
// sequencer for the graph store and depth-first walk
// depends on gdfs_pkg
module gdfs_ctrl
    import gdfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t ctl
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    status_t decision;

    // status of a transaction as soon as its operands are known
    always_comb
    begin
        decision = STAT_OK;
        unique case (stat.op)
            OP_CLEAR:
            begin
                decision = STAT_OK;
            end
            OP_INS_VERTEX:
            begin
                if (stat.v_bad)
                    decision = STAT_INVALID;
                else if (stat.v_present)
                    decision = STAT_EXISTS;
            end
            OP_INS_EDGE:
            begin
                if (stat.v_bad || stat.u_bad)
                    decision = STAT_INVALID;
                else if (!stat.v_present || !stat.u_present)
                    decision = STAT_MISSING;
                else if (stat.same)
                    decision = STAT_EDGE_EXISTS;
            end
            OP_SEARCH:
            begin
                if (stat.v_bad)
                    decision = STAT_INVALID;
                else if (!stat.v_present)
                    decision = STAT_MISSING;
            end
            default:
            begin
                decision = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        status_next = status_reg;
        if (state_reg == S_DECODE)
            status_next = decision;
        else if (state_reg == S_EDGE_A && stat.edge_set)
            status_next = STAT_EDGE_EXISTS;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (decision != STAT_OK || stat.op == OP_CLEAR || stat.op == OP_INS_VERTEX)
                    state_next = S_REPORT;
                else if (stat.op == OP_INS_EDGE)
                    state_next = S_EDGE_A;
                else
                    state_next = S_ROW_RD;
            end
            S_EDGE_A:
            begin
                state_next = stat.edge_set ? S_REPORT : S_EDGE_B;
            end
            S_EDGE_B:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (stat.slot_free)
                    state_next = S_IDLE;
            end
            S_ROW_RD:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (stat.open_any)
                begin
                    if (stat.slot_free)
                        state_next = S_ROW_RD;
                end
                else if (stat.depth_one)
                    state_next = S_FINAL;
                else
                    state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                state_next = S_POP_TOP;
            end
            S_POP_TOP:
            begin
                state_next = S_PICK;
            end
            S_FINAL:
            begin
                if (stat.slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        ctl           = '0;
        ctl.adj_sel   = ASEL_A;
        ctl.rsp_status = status_reg;
        cmd_stall     = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.latch_cmd = cmd_valid;
            end
            S_DECODE:
            begin
                if (stat.op == OP_CLEAR)
                    ctl.clear_graph = 1'b1;
                else if (decision == STAT_OK)
                begin
                    if (stat.op == OP_INS_VERTEX)
                        ctl.set_present = 1'b1;
                    else if (stat.op == OP_INS_EDGE)
                    begin
                        ctl.adj_rd  = 1'b1;
                        ctl.adj_sel = ASEL_A;
                    end
                    else
                        ctl.search_init = 1'b1;
                end
            end
            S_EDGE_A:
            begin
                if (!stat.edge_set)
                begin
                    ctl.adj_wr  = 1'b1;
                    ctl.adj_rd  = 1'b1;
                    ctl.adj_sel = ASEL_B;
                end
            end
            S_EDGE_B:
            begin
                ctl.adj_wr   = 1'b1;
                ctl.adj_wr_b = 1'b1;
            end
            S_REPORT:
            begin
                ctl.emit_status = stat.slot_free;
            end
            S_ROW_RD:
            begin
                ctl.adj_rd  = 1'b1;
                ctl.adj_sel = ASEL_PEND;
            end
            S_PICK:
            begin
                if (stat.open_any)
                begin
                    ctl.push      = stat.slot_free;
                    ctl.emit_pend = stat.slot_free;
                end
                else
                    ctl.pop = 1'b1;
            end
            S_POP_RD:
            begin
                ctl.stack_rd = 1'b1;
            end
            S_POP_TOP:
            begin
                ctl.adj_rd  = 1'b1;
                ctl.adj_sel = ASEL_STACK;
            end
            S_FINAL:
            begin
                ctl.emit_pend = stat.slot_free;
                ctl.emit_last = 1'b1;
            end
            default:
            begin
                ctl.latch_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ sv/gdfs_dp.sv @@
// datapath: vertex and visited bits, adjacency rows, walk stack, result register
// depends on gdfs_pkg and gdfs_ram
module gdfs_dp
    import gdfs_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  ctrl_cmd_t ctl,
    output dp_stat_t  stat,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output rsp_t      rsp
);

    localparam int IDX_W   = $clog2(NUM_VERTICES);
    localparam int DEPTH_W = $clog2(NUM_VERTICES + 1);
    localparam logic [NUM_VERTICES-1:0] ONE_ROW = {{(NUM_VERTICES-1){1'b0}}, 1'b1};

    cmd_t                    cmd_reg;
    logic [NUM_VERTICES-1:0] present_reg, present_next;
    logic [NUM_VERTICES-1:0] visited_reg, visited_next;
    logic [NUM_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [IDX_W-1:0]        pend_reg, pend_next;
    logic                    adj_rvld_reg;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]        v_idx, u_idx, next_idx;
    logic [NUM_VERTICES-1:0] adj_rdata, adj_row, open_vec, adj_wdata;
    logic [IDX_W-1:0]        adj_raddr, adj_waddr;
    logic [IDX_W-1:0]        stk_rdata, stk_waddr, stk_wdata, stk_raddr;
    logic                    stk_we;
    logic                    slot_free;
    logic [DEPTH_W-1:0]      depth_m1;
    logic [IDX_W+VIS_W-1:0]  pend_ext;

    assign v_idx     = cmd_reg.vertex[IDX_W-1:0];
    assign u_idx     = cmd_reg.other_vertex[IDX_W-1:0];
    assign adj_row   = adj_rvld_reg ? adj_rdata : '0;
    assign open_vec  = adj_row & ~visited_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign depth_m1  = depth_reg - DEPTH_W'(1);
    assign pend_ext  = {{VIS_W{1'b0}}, pend_reg};

    // lowest open neighbour
    always_comb
    begin
        next_idx = '0;
        for (int i = NUM_VERTICES - 1; i >= 0; i--)
        begin
            if (open_vec[i])
                next_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        stat.op        = cmd_reg.op;
        stat.v_bad     = cmd_reg.vertex >= VERT_W'(NUM_VERTICES);
        stat.u_bad     = cmd_reg.other_vertex >= VERT_W'(NUM_VERTICES);
        stat.v_present = present_reg[v_idx];
        stat.u_present = present_reg[u_idx];
        stat.same      = cmd_reg.vertex == cmd_reg.other_vertex;
        stat.edge_set  = adj_row[u_idx];
        stat.open_any  = |open_vec;
        stat.depth_one = depth_reg == DEPTH_W'(1);
        stat.slot_free = slot_free;
    end

    // adjacency row store
    always_comb
    begin
        unique case (ctl.adj_sel)
            ASEL_A:     adj_raddr = v_idx;
            ASEL_B:     adj_raddr = u_idx;
            ASEL_PEND:  adj_raddr = pend_reg;
            ASEL_STACK: adj_raddr = stk_rdata;
            default:    adj_raddr = v_idx;
        endcase
        adj_waddr = ctl.adj_wr_b ? u_idx : v_idx;
        adj_wdata = adj_row | (ONE_ROW << (ctl.adj_wr_b ? v_idx : u_idx));
    end

    gdfs_ram #(
        .WIDTH (NUM_VERTICES),
        .DEPTH (NUM_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ctl.adj_wr),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (ctl.adj_rd),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // walk stack
    assign stk_we    = ctl.search_init || ctl.push;
    assign stk_waddr = ctl.search_init ? '0 : depth_reg[IDX_W-1:0];
    assign stk_wdata = ctl.search_init ? v_idx : next_idx;
    assign stk_raddr = depth_m1[IDX_W-1:0];

    gdfs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (ctl.stack_rd),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        present_next   = present_reg;
        visited_next   = visited_reg;
        row_valid_next = row_valid_reg;
        depth_next     = depth_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (ctl.clear_graph)
        begin
            present_next   = '0;
            visited_next   = '0;
            row_valid_next = '0;
            depth_next     = '0;
        end
        if (ctl.set_present)
            present_next = present_reg | (ONE_ROW << v_idx);
        if (ctl.adj_wr)
            row_valid_next = row_valid_reg | (ONE_ROW << adj_waddr);
        if (ctl.search_init)
        begin
            visited_next = ONE_ROW << v_idx;
            depth_next   = DEPTH_W'(1);
            pend_next    = v_idx;
        end
        if (ctl.push)
        begin
            visited_next = visited_reg | (ONE_ROW << next_idx);
            depth_next   = depth_reg + DEPTH_W'(1);
            pend_next    = next_idx;
        end
        if (ctl.pop)
            depth_next = depth_m1;
        if (ctl.emit_status)
        begin
            rsp_next.visited_vertex = '0;
            rsp_next.status         = ctl.rsp_status;
            rsp_next.last           = 1'b1;
            rsp_valid_next          = 1'b1;
        end
        if (ctl.emit_pend)
        begin
            rsp_next.visited_vertex = pend_ext[VIS_W-1:0];
            rsp_next.status         = STAT_OK;
            rsp_next.last           = ctl.emit_last;
            rsp_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            visited_reg   <= '0;
            row_valid_reg <= '0;
            depth_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            adj_rvld_reg  <= 1'b0;
        end
        else
        begin
            present_reg   <= present_next;
            visited_reg   <= visited_next;
            row_valid_reg <= row_valid_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.adj_rd)
                adj_rvld_reg <= row_valid_next[adj_raddr] && !ctl.clear_graph
                                && (row_valid_reg[adj_raddr] || (ctl.adj_wr && adj_waddr == adj_raddr));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_cmd)
            cmd_reg <= cmd;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> depth_reg < DEPTH_W'(NUM_VERTICES))
        else $error("walk stack overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> depth_reg != '0)
        else $error("walk stack underflow");

    a_push_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !visited_reg[next_idx])
        else $error("vertex visited twice");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit_pend || ctl.emit_status) |-> slot_free)
        else $error("result register overwritten");

endmodule

@@ sv/graph_depth_first_search_top.sv @@
// graph store with depth-first search: clear, insert vertex, insert edge, search
// each transaction ends with its result in the result register; a search emits each reached
// vertex in turn and backtracks through the walk stack, paced by the registered reads of the
// adjacency and stack rams; one transaction at a time
// reset: asynchronous, empties the graph and the result register; no clearing pass
// depends on gdfs_pkg, gdfs_ctrl, gdfs_dp
module graph_depth_first_search_top
    import gdfs_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    gdfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    gdfs_dp #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
